@@ hw/rtl/bsmm_pkg.sv @@
package bsmm_pkg;

   // fixed field widths
   localparam int DATA_W     = 32;
   localparam int CSR_DATA_W = 3;
   localparam int CSR_IDX_W  = 3;
   // clamped dimension, wide enough for the largest supported block edge
   localparam int DIM_W      = 4;
   // is_b and last flags that ride with each queued element
   localparam int CMD_TAG_W  = 2;

   localparam logic ACT_A = 1'b0;
   localparam logic ACT_B = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_OUT   = 3'd0,
      CSR_COLS_OUT   = 3'd1,
      CSR_INNER_SIZE = 3'd2,
      CSR_ROW_MAJOR  = 3'd3
   } csr_index_type;

   typedef enum logic {
      BK_LOAD,
      BK_CALC
   } bk_state_type;

   // clamped block shape, front to back
   typedef struct packed {
      logic [DIM_W-1:0] rows;
      logic [DIM_W-1:0] cols;
      logic [DIM_W-1:0] inner;
      logic             row_major;
   } cfg_type;

endpackage

@@ hw/rtl/bsmm_ram.sv @@
module bsmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/bsmm_queue.sv @@
module bsmm_queue #(
   parameter int WIDTH = 40,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/bsmm_front.sv @@
module bsmm_front #(
   parameter int MAX_DIM = 4,
   parameter int CMD_W   = 38
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic signed [bsmm_pkg::DATA_W-1:0]    req_elem_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsmm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bsmm_pkg::CSR_DATA_W-1:0]       csr_data,
   output bsmm_pkg::cfg_type                     cfg,
   output logic                                  push_valid,
   input  logic                                  push_ready,
   output logic [CMD_W-1:0]                      push_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int SW    = 2 * bsmm_pkg::DIM_W;

   function automatic logic [bsmm_pkg::DIM_W-1:0] clamp_dim(
      input logic [bsmm_pkg::CSR_DATA_W-1:0] v
   );
      logic [bsmm_pkg::DIM_W-1:0] w;
      w = bsmm_pkg::DIM_W'(v);
      if (w == '0) begin
         return bsmm_pkg::DIM_W'(1);
      end else if (w > bsmm_pkg::DIM_W'(MAX_DIM)) begin
         return bsmm_pkg::DIM_W'(MAX_DIM);
      end
      return w;
   endfunction

   logic [bsmm_pkg::CSR_DATA_W-1:0] rows_ff, rows_in;
   logic [bsmm_pkg::CSR_DATA_W-1:0] cols_ff, cols_in;
   logic [bsmm_pkg::CSR_DATA_W-1:0] inner_ff, inner_in;
   logic                            row_major_ff, row_major_in;
   logic [CW-1:0]                   a_count_ff, a_count_in;
   logic [CW-1:0]                   b_count_ff, b_count_in;

   logic            csr_hit, accept, wr_a, wr_b, done;
   logic [SW-1:0]   a_size_full, b_size_full;
   logic [CW-1:0]   a_size, b_size, a_next, b_next;
   logic [AW-1:0]   wr_addr;

   assign csr_ready = 1'b1;
   assign csr_hit   = csr_valid && (csr_index inside {bsmm_pkg::CSR_ROWS_OUT,
      bsmm_pkg::CSR_COLS_OUT, bsmm_pkg::CSR_INNER_SIZE, bsmm_pkg::CSR_ROW_MAJOR});

   assign cfg.rows      = clamp_dim(rows_ff);
   assign cfg.cols      = clamp_dim(cols_ff);
   assign cfg.inner     = clamp_dim(inner_ff);
   assign cfg.row_major = row_major_ff;

   assign a_size_full = SW'(cfg.rows) * SW'(cfg.inner);
   assign b_size_full = SW'(cfg.inner) * SW'(cfg.cols);
   assign a_size      = CW'(a_size_full);
   assign b_size      = CW'(b_size_full);

   // an element for a block already full is taken and dropped
   assign wr_a   = (req_action == bsmm_pkg::ACT_A) && (a_count_ff < a_size);
   assign wr_b   = (req_action == bsmm_pkg::ACT_B) && (b_count_ff < b_size);
   assign a_next = wr_a ? a_count_ff + CW'(1) : a_count_ff;
   assign b_next = wr_b ? b_count_ff + CW'(1) : b_count_ff;
   assign done   = (a_next >= a_size) && (b_next >= b_size);

   assign req_ready  = push_ready;
   assign accept     = req_valid && req_ready;
   assign push_valid = req_valid && (wr_a || wr_b);
   assign wr_addr    = wr_a ? a_count_ff[AW-1:0] : b_count_ff[AW-1:0];
   assign push_data  = {wr_b, done, req_elem_value, wr_addr};

   always_comb begin
      rows_in      = rows_ff;
      cols_in      = cols_ff;
      inner_in     = inner_ff;
      row_major_in = row_major_ff;
      a_count_in   = a_count_ff;
      b_count_in   = b_count_ff;
      if (accept) begin
         a_count_in = done ? '0 : a_next;
         b_count_in = done ? '0 : b_next;
      end
      if (csr_valid) begin
         case (bsmm_pkg::csr_index_type'(csr_index))
            bsmm_pkg::CSR_ROWS_OUT:   rows_in      = csr_data;
            bsmm_pkg::CSR_COLS_OUT:   cols_in      = csr_data;
            bsmm_pkg::CSR_INNER_SIZE: inner_in     = csr_data;
            bsmm_pkg::CSR_ROW_MAJOR:  row_major_in = csr_data[0];
            default: ;
         endcase
      end
      // any write in the list drops a partly loaded pair
      if (csr_hit) begin
         a_count_in = '0;
         b_count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= bsmm_pkg::CSR_DATA_W'(4);
         cols_ff      <= bsmm_pkg::CSR_DATA_W'(4);
         inner_ff     <= bsmm_pkg::CSR_DATA_W'(4);
         row_major_ff <= 1'b1;
         a_count_ff   <= '0;
         b_count_ff   <= '0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         inner_ff     <= inner_in;
         row_major_ff <= row_major_in;
         a_count_ff   <= a_count_in;
         b_count_ff   <= b_count_in;
      end
   end

endmodule

@@ hw/rtl/bsmm_back.sv @@
module bsmm_back #(
   parameter int MAX_DIM = 4,
   parameter int CMD_W   = 38
) (
   input  logic                               clock,
   input  logic                               reset,
   input  bsmm_pkg::cfg_type                  cfg,
   input  logic                               pop_valid,
   output logic                               pop_ready,
   input  logic [CMD_W-1:0]                   pop_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [bsmm_pkg::DATA_W-1:0] rsp_prod_value,
   output logic                               rsp_clipped,
   output logic                               rsp_block_last
);

   localparam int DW    = bsmm_pkg::DATA_W;
   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int PW    = 2 * DW;
   localparam int ACC_W = PW + 2 + $clog2(MAX_DIM);
   localparam int NW    = bsmm_pkg::DIM_W;

   // queued element
   logic [AW-1:0] cmd_addr;
   logic [DW-1:0] cmd_value;
   logic          cmd_last, cmd_is_b;

   assign cmd_addr  = pop_data[AW-1:0];
   assign cmd_value = pop_data[AW+DW-1:AW];
   assign cmd_last  = pop_data[AW+DW];
   assign cmd_is_b  = pop_data[AW+DW+1];

   bsmm_pkg::bk_state_type state_ff, state_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   logic          adv, issue, pop;
   logic          i_end, j_end, k_end, elem_end;
   logic [AW-1:0] a_addr, b_addr;
   logic [DW-1:0] a_rd, b_rd;

   // pipeline: read, multiply, accumulate, round
   logic                    s1_valid_ff, s1_first_ff, s1_lastk_ff, s1_blast_ff;
   logic                    s2_valid_ff, s2_first_ff, s2_lastk_ff, s2_blast_ff;
   logic signed [PW-1:0]    prod_ff;
   logic                    acc_done_ff, acc_blast_ff;
   logic signed [ACC_W-1:0] acc_ff, prod_ext, rnd;
   logic                    fits;
   logic                    rsp_valid_ff;
   logic [DW-1:0]           rsp_value_ff;
   logic                    rsp_clip_ff, rsp_last_ff;

   assign adv = !rsp_valid_ff || rsp_ready;

   assign i_end    = (NW'(i_ff) + NW'(1) == cfg.rows);
   assign j_end    = (NW'(j_ff) + NW'(1) == cfg.cols);
   assign k_end    = (NW'(k_ff) + NW'(1) == cfg.inner);
   assign elem_end = i_end && j_end && k_end;

   assign a_addr = cfg.row_major ? AW'(i_ff) * AW'(cfg.inner) + AW'(k_ff)
                                 : AW'(k_ff) * AW'(cfg.rows) + AW'(i_ff);
   assign b_addr = cfg.row_major ? AW'(k_ff) * AW'(cfg.cols) + AW'(j_ff)
                                 : AW'(j_ff) * AW'(cfg.inner) + AW'(k_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsmm_pkg::BK_LOAD: if (pop && cmd_last) state_in = bsmm_pkg::BK_CALC;
         bsmm_pkg::BK_CALC: if (issue && elem_end) state_in = bsmm_pkg::BK_LOAD;
         default:           state_in = bsmm_pkg::BK_LOAD;
      endcase
   end

   always_comb begin
      pop   = 1'b0;
      issue = 1'b0;
      case (state_ff)
         bsmm_pkg::BK_LOAD: pop   = pop_valid;
         bsmm_pkg::BK_CALC: issue = adv;
         default: ;
      endcase
   end

   assign pop_ready = pop;

   // walk C in storage order, k innermost
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      if (pop && cmd_last) begin
         i_in = '0;
         j_in = '0;
         k_in = '0;
      end else if (issue) begin
         if (!k_end) begin
            k_in = k_ff + IW'(1);
         end else begin
            k_in = '0;
            if (cfg.row_major) begin
               j_in = j_end ? '0 : j_ff + IW'(1);
               if (j_end) i_in = i_end ? '0 : i_ff + IW'(1);
            end else begin
               i_in = i_end ? '0 : i_ff + IW'(1);
               if (i_end) j_in = j_end ? '0 : j_ff + IW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsmm_pkg::BK_LOAD;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   bsmm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_a_store (
      .clock   (clock),
      .wr_en   (pop && !cmd_is_b),
      .wr_addr (cmd_addr),
      .wr_data (cmd_value),
      .rd_en   (adv),
      .rd_addr (a_addr),
      .rd_data (a_rd)
   );

   bsmm_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_b_store (
      .clock   (clock),
      .wr_en   (pop && cmd_is_b),
      .wr_addr (cmd_addr),
      .wr_data (cmd_value),
      .rd_en   (adv),
      .rd_addr (b_addr),
      .rd_data (b_rd)
   );

   assign prod_ext = {{(ACC_W - PW){prod_ff[PW-1]}}, prod_ff};
   assign rnd      = acc_ff + ACC_W'(32768);
   assign fits     = (&rnd[ACC_W-1:PW-17]) || !(|rnd[ACC_W-1:PW-17]);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         acc_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= issue;
         s2_valid_ff  <= s1_valid_ff;
         acc_done_ff  <= s2_valid_ff && s2_lastk_ff;
         rsp_valid_ff <= acc_done_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_first_ff <= (k_ff == '0);
         s1_lastk_ff <= k_end;
         s1_blast_ff <= i_end && j_end;
         s2_first_ff <= s1_first_ff;
         s2_lastk_ff <= s1_lastk_ff;
         s2_blast_ff <= s1_blast_ff;
         prod_ff     <= $signed(a_rd) * $signed(b_rd);
         if (s2_valid_ff) begin
            acc_ff       <= s2_first_ff ? prod_ext : acc_ff + prod_ext;
            acc_blast_ff <= s2_blast_ff;
         end
         if (acc_done_ff) begin
            rsp_clip_ff  <= !fits;
            rsp_last_ff  <= acc_blast_ff;
            rsp_value_ff <= fits ? rnd[PW-17:16]
                                 : (rnd[ACC_W-1] ? {1'b1, {(DW-1){1'b0}}}
                                                 : {1'b0, {(DW-1){1'b1}}});
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prod_value = rsp_value_ff;
   assign rsp_clipped    = rsp_clip_ff;
   assign rsp_block_last = rsp_last_ff;

endmodule

@@ hw/rtl/batched_small_matrix_multiply.sv @@
// channel   direction  transfer when        payload
// req       in         req_valid & ready    req_action, req_elem_value
// rsp       out        rsp_valid & ready    rsp_prod_value, rsp_clipped, rsp_block_last
// csr       in         csr_valid & ready    csr_index, csr_data
//
// the back loads every element of a pair from the queue, then forms rows*cols*inner
// products on the single multiply-accumulate path and takes no new element meanwhile
// each result passes the read, multiply, accumulate and round pipeline stages
// the front takes one transfer per cycle while the element queue has room
// reset is synchronous and clears counts, queue and valid flags, loads config defaults
// a stalled rsp freezes the compute pipeline, the queue then fills and stalls req
module batched_small_matrix_multiply #(
   parameter int MAX_DIM     = 4,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_action,
   input  logic signed [bsmm_pkg::DATA_W-1:0]    req_elem_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bsmm_pkg::DATA_W-1:0]    rsp_prod_value,
   output logic                                  rsp_clipped,
   output logic                                  rsp_block_last,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [bsmm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bsmm_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   // queued element: is_b, last-of-pair, value, store address
   localparam int CMD_W = AW + bsmm_pkg::DATA_W + bsmm_pkg::CMD_TAG_W;

   bsmm_pkg::cfg_type cfg;
   logic              push_valid, push_ready;
   logic [CMD_W-1:0]  push_data;
   logic              pop_valid, pop_ready;
   logic [CMD_W-1:0]  pop_data;

   // front: config registers, load counts, element classification
   bsmm_front #(.MAX_DIM(MAX_DIM), .CMD_W(CMD_W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_elem_value (req_elem_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cfg            (cfg),
      .push_valid     (push_valid),
      .push_ready     (push_ready),
      .push_data      (push_data)
   );

   // decouples loading from compute
   bsmm_queue #(.WIDTH(CMD_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: element stores, multiply-accumulate, rounding and saturation
   bsmm_back #(.MAX_DIM(MAX_DIM), .CMD_W(CMD_W)) u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_data       (pop_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_prod_value (rsp_prod_value),
      .rsp_clipped    (rsp_clipped),
      .rsp_block_last (rsp_block_last)
   );

endmodule
